// ===== rtl/pps_pkg.sv =====
// Shared constants, codes and controller/datapath bundles for the polygon plane split.
// No dependencies.
package pps_pkg;

    localparam int MAX_VERTS = 64;
    localparam int CNT_W     = $clog2(MAX_VERTS) + 1;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_NX = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NY = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NZ = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_D  = 8'd3;

    localparam logic [1:0] K_X    = 2'd0;
    localparam logic [1:0] K_B    = 2'd1;
    localparam logic [1:0] K_MARK = 2'd2;

    localparam logic [30:0] ONE_T = 31'h4000_0000;

    typedef struct packed {
        logic       accept;
        logic       calc_dist;
        logic [1:0] dist_idx;
        logic       store_first;
        logic       copy_prev;
        logic       bsel;
        logic       div_start;
        logic       div_step;
        logic       lerp_mul;
        logic       lerp_add;
        logic [2:0] lerp_idx;
        logic       load;
        logic [1:0] load_kind;
        logic       load_side;
        logic       release_beat;
        logic       finish;
        logic       finish_done;
    } t_cmd;

    typedef struct packed {
        logic s0;
        logic s1;
        logic div_trivial;
        logic slot_full;
        logic slot_rel;
    } t_stat;

endpackage

// ===== rtl/pps_vtx_if.sv =====
// Vertex input channel: valid/ready plus one vertex beat.
// No dependencies.
interface pps_vtx_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
    logic        last_vertex;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, last_vertex,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, last_vertex,
                    output ready);
endinterface

// ===== rtl/pps_res_if.sv =====
// Result output channel: valid/ready plus one emitted vertex beat.
// No dependencies.
interface pps_res_if;
    logic        valid;
    logic        ready;
    logic        side;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [31:0] out_u;
    logic [31:0] out_v;
    logic        run_last;
    logic        polygon_done;
    logic        too_large;

    modport source (output valid, side, out_x, out_y, out_z, out_u, out_v, run_last,
                    polygon_done, too_large, input ready);
    modport sink   (input valid, side, out_x, out_y, out_z, out_u, out_v, run_last,
                    polygon_done, too_large, output ready);
endinterface

// ===== rtl/polygon_plane_split_core.sv =====
// Polygon plane split: splits a streamed polygon into back and front vertex lists.
// Depends on pps_pkg, pps_vtx_if, pps_res_if, pps_ctrl and pps_datapath.
// One vertex is taken at a time. Each crossing edge adds the bit-serial divider (one
// quotient bit per cycle; it stops early when the end distance is zero) and the
// interpolation on the single shared 33x32 multiplier. Every beat after the first of a
// vertex takes a release, a hand-off and a load while the receiver stays ready, and a
// stalled receiver holds the controller in place. The last beat of a vertex waits in an
// output register while the next vertex is already being worked on.
module polygon_plane_split_core import pps_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    pps_vtx_if.sink              i_vtx,
    pps_res_if.source            o_res
);

    t_cmd  cmd;
    t_stat stat;

    pps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_vtx.valid),
        .i_in_last  (i_vtx.last_vertex),
        .o_in_ready (i_vtx.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pps_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_pos_x        (i_vtx.pos_x),
        .i_pos_y        (i_vtx.pos_y),
        .i_pos_z        (i_vtx.pos_z),
        .i_tex_u        (i_vtx.tex_u),
        .i_tex_v        (i_vtx.tex_v),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_side         (o_res.side),
        .o_out_x        (o_res.out_x),
        .o_out_y        (o_res.out_y),
        .o_out_z        (o_res.out_z),
        .o_out_u        (o_res.out_u),
        .o_out_v        (o_res.out_v),
        .o_run_last     (o_res.run_last),
        .o_polygon_done (o_res.polygon_done),
        .o_too_large    (o_res.too_large)
    );

    a_marker_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.too_large |-> !o_res.side && o_res.out_x == 32'd0)
        else $error("overflow marker not on back side with zero position");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vtx.valid && i_vtx.ready |=> !i_vtx.ready)
        else $error("vertex accepted while previous one still in work");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.polygon_done |-> o_res.run_last)
        else $error("polygon end flagged on a beat that is not the last of its vertex");

endmodule

// ===== rtl/pps_datapath.sv =====
// Datapath: plane registers, vertex stores, shared multiplier, bit-serial divider,
// interpolation and the output holding register. Depends on pps_pkg.
module pps_datapath import pps_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic [31:0]          i_pos_x,
    input  logic [31:0]          i_pos_y,
    input  logic [31:0]          i_pos_z,
    input  logic [31:0]          i_tex_u,
    input  logic [31:0]          i_tex_v,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_side,
    output logic [31:0]          o_out_x,
    output logic [31:0]          o_out_y,
    output logic [31:0]          o_out_z,
    output logic [31:0]          o_out_u,
    output logic [31:0]          o_out_v,
    output logic                 o_run_last,
    output logic                 o_polygon_done,
    output logic                 o_too_large
);

    logic [31:0]        r_cfg   [4];
    logic [31:0]        r_cur   [5];
    logic [31:0]        r_prev  [5];
    logic [31:0]        r_first [5];
    logic [31:0]        r_x     [5];
    logic [31:0]        r_o     [5];
    logic signed [63:0] r_cur_d, r_prev_d, r_first_d, r_acc, r_prod;
    logic [65:0]        r_rem;
    logic [64:0]        r_den;
    logic [30:0]        r_q;
    logic               r_triv;
    logic               r_full, r_rel;
    logic               r_side, r_run_last, r_pdone, r_big;

    logic [31:0]        b_v [5];
    logic signed [63:0] d0, d1, prod_sh, rnd, lsh, dmul;
    logic [63:0]        a0, a1;
    logic [64:0]        den;
    logic [65:0]        rem2;
    logic signed [32:0] mul_a, diff;
    logic signed [31:0] mul_b;
    logic signed [64:0] mul_p;
    logic               triv;
    logic [31:0]        d_cfg;

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            b_v[k] = i_cmd.bsel ? r_first[k] : r_cur[k];
        end
        d0      = r_prev_d;
        d1      = i_cmd.bsel ? r_first_d : r_cur_d;
        a0      = d0[63] ? 64'd0 - 64'(d0) : 64'(d0);
        a1      = d1[63] ? 64'd0 - 64'(d1) : 64'(d1);
        den     = {1'b0, a0} + {1'b0, a1};
        triv    = ({1'b0, a0} >= den);
        rem2    = {r_rem[64:0], 1'b0};
        diff    = $signed({b_v[i_cmd.lerp_idx][31], b_v[i_cmd.lerp_idx]})
                - $signed({r_prev[i_cmd.lerp_idx][31], r_prev[i_cmd.lerp_idx]});
        if (i_cmd.lerp_mul) begin
            mul_a = diff;
            mul_b = $signed({1'b0, r_q});
        end else begin
            mul_a = $signed({r_cfg[i_cmd.dist_idx][31], r_cfg[i_cmd.dist_idx]});
            mul_b = $signed(r_cur[{1'b0, i_cmd.dist_idx}]);
        end
        mul_p   = 65'(mul_a) * 65'(mul_b);
        prod_sh = r_prod >>> 2;
        rnd     = r_prod + 64'sd536870912;
        lsh     = rnd >>> 30;
        d_cfg   = r_cfg[3];
        dmul    = $signed({{18{d_cfg[31]}}, d_cfg, 14'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_cfg[k] <= '0;
            end
            for (int k = 0; k < 5; k++) begin
                r_prev[k]  <= '0;
                r_first[k] <= '0;
            end
            r_prev_d   <= '0;
            r_first_d  <= '0;
            r_full     <= 1'b0;
            r_rel      <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx <= CFG_D) begin
                r_cfg[i_cfg_idx[1:0]] <= i_cfg_data;
            end
            if (i_cmd.store_first) begin
                r_first   <= r_cur;
                r_first_d <= r_cur_d;
            end
            if (i_cmd.copy_prev) begin
                r_prev   <= r_cur;
                r_prev_d <= r_cur_d;
            end
            if (o_out_valid && i_out_ready) begin
                r_full <= 1'b0;
                r_rel  <= 1'b0;
            end
            if (i_cmd.load) begin
                r_full <= 1'b1;
                r_rel  <= 1'b0;
            end
            if (i_cmd.release_beat || i_cmd.finish) begin
                r_rel <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur[0] <= i_pos_x;
            r_cur[1] <= i_pos_y;
            r_cur[2] <= i_pos_z;
            r_cur[3] <= i_tex_u;
            r_cur[4] <= i_tex_v;
        end
        if (i_cmd.calc_dist || i_cmd.lerp_mul) begin
            r_prod <= mul_p[63:0];
        end
        if (i_cmd.calc_dist) begin
            unique case (i_cmd.dist_idx)
                2'd0:    r_acc <= -dmul;
                2'd3:    r_cur_d <= r_acc + prod_sh;
                default: r_acc <= r_acc + prod_sh;
            endcase
        end
        if (i_cmd.div_start) begin
            r_rem  <= {2'b0, a0};
            r_den  <= den;
            r_triv <= triv;
            r_q    <= triv ? ONE_T : '0;
        end else if (i_cmd.div_step) begin
            if (rem2 >= {1'b0, r_den}) begin
                r_rem <= rem2 - {1'b0, r_den};
                r_q   <= {r_q[29:0], 1'b1};
            end else begin
                r_rem <= rem2;
                r_q   <= {r_q[29:0], 1'b0};
            end
        end
        if (i_cmd.lerp_add) begin
            r_x[i_cmd.lerp_idx] <= r_prev[i_cmd.lerp_idx] + lsh[31:0];
        end
        if (i_cmd.load) begin
            r_side     <= i_cmd.load_side;
            r_run_last <= 1'b0;
            r_pdone    <= 1'b0;
            r_big      <= (i_cmd.load_kind == K_MARK);
            for (int k = 0; k < 5; k++) begin
                unique case (i_cmd.load_kind)
                    K_X:     r_o[k] <= r_x[k];
                    K_B:     r_o[k] <= b_v[k];
                    default: r_o[k] <= '0;
                endcase
            end
        end
        if (i_cmd.finish) begin
            r_run_last <= 1'b1;
            r_pdone    <= i_cmd.finish_done;
        end
    end

    assign o_stat.s0          = !d0[63] && (d0 != 64'sd0);
    assign o_stat.s1          = !d1[63] && (d1 != 64'sd0);
    assign o_stat.div_trivial = r_triv;
    assign o_stat.slot_full   = r_full;
    assign o_stat.slot_rel    = r_rel;

    assign o_out_valid    = r_full && r_rel;
    assign o_side         = r_side;
    assign o_out_x        = r_o[0];
    assign o_out_y        = r_o[1];
    assign o_out_z        = r_o[2];
    assign o_out_u        = r_o[3];
    assign o_out_v        = r_o[4];
    assign o_run_last     = r_run_last;
    assign o_polygon_done = r_pdone;
    assign o_too_large    = r_big;

endmodule

// ===== rtl/pps_ctrl.sv =====
// Controller: sequences distance, edge classification, division, interpolation
// and result emission; holds side counts and polygon flags. Depends on pps_pkg.
module pps_ctrl import pps_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_last,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIST = 4'd1;
    localparam logic [3:0] S_FST  = 4'd2;
    localparam logic [3:0] S_ADV  = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_DIVI = 4'd5;
    localparam logic [3:0] S_DIVR = 4'd6;
    localparam logic [3:0] S_LMUL = 4'd7;
    localparam logic [3:0] S_LADD = 4'd8;
    localparam logic [3:0] S_EMIT = 4'd9;
    localparam logic [3:0] S_MARK = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    localparam logic [1:0] Q_X1   = 2'd0;
    localparam logic [1:0] Q_B1   = 2'd1;
    localparam logic [1:0] Q_X0   = 2'd2;
    localparam logic [1:0] Q_ONLY = 2'd3;

    logic [3:0]       r_state, n_state;
    logic [4:0]       r_cnt, n_cnt;
    logic             r_last, n_last;
    logic             r_closing, n_closing;
    logic             r_fresh, n_fresh;
    logic             r_have, n_have;
    logic             r_ovf, n_ovf;
    logic [CNT_W-1:0] r_back, n_back, r_front, n_front;
    logic [1:0]       r_kind, n_kind, r_seq, n_seq;
    logic             r_eside, n_eside;
    logic [3:0]       edge_next;
    logic             full_soon;

    always_comb begin
        edge_next = r_closing ? S_MARK : S_ADV;
        full_soon = ({1'b0, r_back} + (CNT_W+1)'(2) >= (CNT_W+1)'(MAX_VERTS))
                 || ({1'b0, r_front} + (CNT_W+1)'(2) >= (CNT_W+1)'(MAX_VERTS));
        n_state = r_state;  n_cnt = r_cnt;  n_last = r_last;
        n_closing = r_closing;  n_fresh = r_fresh;  n_have = r_have;
        n_ovf = r_ovf;  n_back = r_back;  n_front = r_front;
        n_kind = r_kind;  n_seq = r_seq;  n_eside = r_eside;
        o_cmd = '0;
        o_cmd.bsel = r_closing;
        o_cmd.dist_idx = r_cnt[1:0];
        o_cmd.lerp_idx = r_cnt[2:0];
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_last = i_in_last;
                    n_cnt = '0;
                    n_fresh = 1'b0;
                    n_closing = 1'b0;
                    n_state = S_DIST;
                end
            end
            S_DIST: begin
                o_cmd.calc_dist = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd3) begin
                    n_state = r_have ? S_CHK : S_FST;
                end
            end
            S_FST: begin
                o_cmd.store_first = 1'b1;
                n_have = 1'b1;
                n_state = S_ADV;
            end
            S_ADV: begin
                o_cmd.copy_prev = 1'b1;
                if (r_last) begin
                    n_closing = 1'b1;
                    n_state = S_CHK;
                end else begin
                    n_state = S_MARK;
                end
            end
            S_CHK: begin
                if (r_ovf) begin
                    n_state = edge_next;
                end else if (full_soon) begin
                    n_ovf = 1'b1;
                    n_fresh = 1'b1;
                    n_state = edge_next;
                end else if (i_stat.s0 == i_stat.s1) begin
                    n_kind = K_B;
                    n_eside = i_stat.s1;
                    n_seq = Q_ONLY;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_DIVI;
                end
            end
            S_DIVI: begin
                o_cmd.div_start = 1'b1;
                n_cnt = '0;
                n_state = S_DIVR;
            end
            S_DIVR: begin
                if (i_stat.div_trivial || r_cnt == 5'd30) begin
                    n_cnt = '0;
                    n_state = S_LMUL;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_LMUL: begin
                o_cmd.lerp_mul = 1'b1;
                n_state = S_LADD;
            end
            S_LADD: begin
                o_cmd.lerp_add = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd4) begin
                    n_kind = K_X;
                    n_eside = i_stat.s1;
                    n_seq = Q_X1;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_LMUL;
                end
            end
            S_EMIT: begin
                if (i_stat.slot_full && !i_stat.slot_rel) begin
                    o_cmd.release_beat = 1'b1;
                end else if (!i_stat.slot_full) begin
                    o_cmd.load = 1'b1;
                    o_cmd.load_kind = r_kind;
                    o_cmd.load_side = r_eside;
                    if (r_kind == K_MARK) begin
                        n_state = S_FIN;
                    end else begin
                        if (r_eside) n_front = r_front + CNT_W'(1);
                        else         n_back = r_back + CNT_W'(1);
                        unique case (r_seq)
                            Q_X1: begin
                                n_kind = K_B;
                                n_seq = Q_B1;
                            end
                            Q_B1: begin
                                n_kind = K_X;
                                n_eside = i_stat.s0;
                                n_seq = Q_X0;
                            end
                            default: n_state = edge_next;
                        endcase
                    end
                end
            end
            S_MARK: begin
                if (r_ovf && (r_fresh || r_last)) begin
                    n_kind = K_MARK;
                    n_eside = 1'b0;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.slot_full && !i_stat.slot_rel) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.finish_done = r_last;
                end
                if (r_last) begin
                    n_have = 1'b0;
                    n_back = '0;
                    n_front = '0;
                    n_ovf = 1'b0;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_have  <= 1'b0;
            r_ovf   <= 1'b0;
            r_back  <= '0;
            r_front <= '0;
        end else begin
            r_state <= n_state;
            r_have  <= n_have;
            r_ovf   <= n_ovf;
            r_back  <= n_back;
            r_front <= n_front;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_last    <= n_last;
        r_closing <= n_closing;
        r_fresh   <= n_fresh;
        r_kind    <= n_kind;
        r_seq     <= n_seq;
        r_eside   <= n_eside;
    end

endmodule

// ===== test/polygon_plane_split_core_tb.sv =====
// Testbench for polygon_plane_split_core: drives polygons through the vertex channel,
// predicts back/front vertex beats in SystemVerilog and checks every result beat.
// Depends on pps_pkg, pps_vtx_if, pps_res_if and the RTL of the core.
module polygon_plane_split_core_tb import pps_pkg::*; ();

    typedef struct packed {
        logic [31:0] x, y, z, u, v;
        logic        lastv;
    } t_vtx;

    typedef struct packed {
        logic        side;
        logic [31:0] x, y, z, u, v;
        logic        run_last, done, big;
    } t_beat;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd9;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    pps_vtx_if vtx ();
    pps_res_if res ();

    polygon_plane_split_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_vtx(vtx.sink), .o_res(res.source)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // plane and split state of the predictor
    logic signed [31:0] plane_n [3];
    logic signed [31:0] plane_d;
    logic [31:0] prev_p [3], prev_t [2], first_p [3], first_t [2];
    logic signed [63:0] prev_dist, first_dist;
    int back_cnt, front_cnt;
    bit have_first, overflow;

    t_beat expected_beats [$];
    t_beat step_beats [$];
    int errors = 0;
    longint cycles = 0;
    bit hold_off = 0;
    bit done_feed = 0;
    int rx_wait = 0;

    function automatic logic signed [63:0] dist_of(logic [31:0] p [3]);
        logic signed [63:0] acc;
        logic signed [63:0] prod;
        acc = 0;
        for (int i = 0; i < 3; i++) begin
            prod = $signed(plane_n[i]) * $signed(p[i]);
            acc += prod >>> 2;
        end
        return acc - ($signed({{32{plane_d[31]}}, plane_d}) <<< 14);
    endfunction

    function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [63:0] t);
        logic signed [63:0] diff;
        logic signed [63:0] prod;
        diff = $signed({{32{b[31]}}, b}) - $signed({{32{a[31]}}, a});
        prod = diff * $signed(t);
        return a + 32'((prod + 64'sd536870912) >>> 30);
    endfunction

    task automatic push_beat(logic side, logic [31:0] p [3], logic [31:0] t [2], logic big);
        t_beat b;
        b = '{side, p[0], p[1], p[2], t[0], t[1], 1'b0, 1'b0, big};
        step_beats.push_back(b);
        if (side) front_cnt++; else back_cnt++;
    endtask

    task automatic split_edge(logic [31:0] ap [3], logic [31:0] at [2], logic signed [63:0] d0,
                              logic [31:0] bp [3], logic [31:0] bt [2], logic signed [63:0] d1,
                              inout bit fresh);
        logic s0, s1;
        logic [63:0] num, den, q, rem;
        logic [31:0] xp [3], xt [2];
        if (overflow) return;
        if (back_cnt + 2 >= MAX_VERTS || front_cnt + 2 >= MAX_VERTS) begin
            overflow = 1;
            fresh = 1;
            return;
        end
        s0 = d0 > 0;
        s1 = d1 > 0;
        if (s0 == s1) begin
            push_beat(s1, bp, bt, 0);
            return;
        end
        num = d0 < 0 ? -d0 : d0;
        den = num + (d1 < 0 ? -d1 : d1);
        q = 0;
        rem = num;
        if (rem >= den) q = 64'h4000_0000;
        else begin
            for (int i = 0; i < 30; i++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= den) begin
                    rem -= den;
                    q[0] = 1;
                end
            end
        end
        for (int i = 0; i < 3; i++) xp[i] = blend(ap[i], bp[i], q);
        for (int i = 0; i < 2; i++) xt[i] = blend(at[i], bt[i], q);
        push_beat(s1, xp, xt, 0);
        push_beat(s1, bp, bt, 0);
        push_beat(s0, xp, xt, 0);
    endtask

    task automatic predict_split(t_vtx it);
        logic [31:0] cp [3], ct [2], zp [3], zt [2];
        logic signed [63:0] cd;
        bit fresh;
        fresh = 0;
        cp = '{it.x, it.y, it.z};
        ct = '{it.u, it.v};
        zp = '{0, 0, 0};
        zt = '{0, 0};
        cd = dist_of(cp);
        step_beats = {};
        if (!have_first) begin
            first_p = cp;
            first_t = ct;
            first_dist = cd;
            have_first = 1;
        end else begin
            split_edge(prev_p, prev_t, prev_dist, cp, ct, cd, fresh);
        end
        prev_p = cp;
        prev_t = ct;
        prev_dist = cd;
        if (it.lastv) split_edge(cp, ct, cd, first_p, first_t, first_dist, fresh);
        if (overflow && (fresh || it.lastv)) begin
            push_beat(0, zp, zt, 1);
            back_cnt--;
        end
        if (step_beats.size() > 0) begin
            step_beats[step_beats.size() - 1].run_last = 1;
            if (it.lastv) step_beats[step_beats.size() - 1].done = 1;
        end
        if (it.lastv) begin
            have_first = 0;
            back_cnt = 0;
            front_cnt = 0;
            overflow = 0;
        end
        foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx == CFG_NX) plane_n[0] = val;
        else if (idx == CFG_NY) plane_n[1] = val;
        else if (idx == CFG_NZ) plane_n[2] = val;
        else if (idx == CFG_D) plane_d = val;
        @(posedge i_clk);
    endtask

    task automatic set_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz, logic [31:0] d);
        write_reg(CFG_NX, nx);
        write_reg(CFG_NY, ny);
        write_reg(CFG_NZ, nz);
        write_reg(CFG_D, d);
    endtask

    task automatic drain_all();
        vtx.valid <= 0;
        while (expected_beats.size() > 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic send_vertex(t_vtx it, bit gaps);
        int idle;
        idle = gaps ? $urandom_range(13, 0) : 0;
        if (idle > 0) begin
            vtx.valid <= 0;
            repeat (idle) @(posedge i_clk);
        end
        vtx.valid <= 1;
        {vtx.pos_x, vtx.pos_y, vtx.pos_z, vtx.tex_u, vtx.tex_v, vtx.last_vertex} <= it;
        do @(posedge i_clk); while (!vtx.ready);
        predict_split(it);
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(5, 0))
            0: return $urandom();
            1: return {$urandom_range(1, 0) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return 32'($signed($urandom_range(4000, 0)) - 2000) <<< 12;
        endcase
    endfunction

    function automatic t_vtx rnd_vertex(bit lastv);
        return '{rnd_coord(), rnd_coord(), rnd_coord(), $urandom(), $urandom(), lastv};
    endfunction

    task automatic send_polygon(int n, bit gaps);
        for (int i = 0; i < n; i++) send_vertex(rnd_vertex(i == n - 1), gaps);
    endtask

    localparam int N_DIRECTED = 10;
    t_vtx dir_vtx [N_DIRECTED] = '{
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1},
        '{32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 1'b0},
        '{32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 1'b0},
        '{32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b1},
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 1'b0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1, 1'b1},
        '{32'h0, 32'h0, 32'h0, 32'h1234_5678, 32'h0, 1'b0},
        '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1},
        '{32'h0003_0000, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
        '{32'hFFFD_0000, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1}
    };
    // expected first beat of row 0 (typed in): single vertex, zero plane, back side
    t_beat dir_first = '{1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF,
                         32'h8000_0000, 1'b1, 1'b1, 1'b0};

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            res.ready <= 0;
        end else begin
            if (res.valid && res.ready) rx_wait = $urandom_range(13, 0);
            else if (rx_wait > 0) rx_wait--;
            res.ready <= (rx_wait == 0);
        end
    end

    always @(posedge i_clk) begin
        t_beat got, want;
        cycles++;
        if (cycles > 400000) begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (i_rst_n && res.valid && res.ready) begin
            got = '{res.side, res.out_x, res.out_y, res.out_z, res.out_u, res.out_v,
                    res.run_last, res.polygon_done, res.too_large};
            if (expected_beats.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat %h", $time, got);
            end else begin
                want = expected_beats.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: beat mismatch expected %h actual %h", $time, want, got);
                end
            end
        end
    end

    initial begin
        vtx.valid = 0;
        {vtx.pos_x, vtx.pos_y, vtx.pos_z, vtx.tex_u, vtx.tex_v, vtx.last_vertex} = '0;
        plane_n = '{0, 0, 0};
        plane_d = 0;
        have_first = 0;
        overflow = 0;
        back_cnt = 0;
        front_cnt = 0;
        prev_dist = 0;
        first_dist = 0;
        prev_p = '{0, 0, 0};
        prev_t = '{0, 0};
        first_p = '{0, 0, 0};
        first_t = '{0, 0};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            if (r == 1) begin
                drain_all();
                set_plane(32'h0001_0000, 32'h0, 32'h0, 32'h0);
            end
            if (r == 4) begin
                drain_all();
                set_plane(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
            end
            if (r == 6) begin
                drain_all();
                set_plane(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF);
            end
            if (r == 8) begin
                drain_all();
                set_plane(32'h0001_0000, 32'h0, 32'h0, 32'h0);
            end
            send_vertex(dir_vtx[r], 0);
            if (r == 0 && expected_beats[0] !== dir_first) begin
                errors++;
                $display("%0t: predictor row 0 expected %h actual %h", $time, dir_first,
                         expected_beats[0]);
            end
        end
        drain_all();
        write_reg(CFG_UNUSED, $urandom());

        // overflow: a long zig-zag polygon across x = 0
        for (int i = 0; i < 48; i++) begin
            t_vtx z;
            z = rnd_vertex(i == 47);
            z.x = (i % 2) ? 32'hFFF0_0000 : 32'h0010_0000;
            send_vertex(z, 1);
        end

        // long receiver stall while the sender keeps offering
        drain_all();
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
            send_polygon(6, 0);
        join

        for (int ph = 0; ph < 6; ph++) begin
            int sent;
            drain_all();
            if (ph == 5) set_plane(32'h0, 32'h0, 32'h0, 32'h8000_0000);
            else set_plane($urandom_range(1, 0) ? $urandom() : (rnd_coord() >>> 4),
                           rnd_coord() >>> 4, rnd_coord() >>> 6, $urandom());
            sent = 0;
            while (sent < 70) begin
                int n;
                n = ($urandom_range(15, 0) == 0) ? $urandom_range(40, 20)
                                                 : $urandom_range(8, 1);
                send_polygon(n, $urandom_range(3, 0) != 0);
                sent += n;
            end
        end

        drain_all();
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
